[rtl/core/quad_fir_with_valve_timeout_unit_defines.svh]
// Assertion macros used by the checker file of the quad FIR block.
`ifndef QUAD_FIR_WITH_VALVE_TIMEOUT_UNIT_DEFINES_SVH
`define QUAD_FIR_WITH_VALVE_TIMEOUT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QFVT_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("qfvt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define QFVT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("qfvt assertion failed");

`endif

[rtl/core/qfvt_pkg.sv]
// Shared types, constants and coefficient table of the quad FIR block.
package qfvt_pkg;

    localparam int MAX_TAPS   = 32;
    localparam int ACC_BITS   = 32;
    localparam int OUT_BITS   = 16;
    localparam int LIMIT_BITS = 6;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 6'd50;

    // m_tuser bit positions
    localparam int USER_COMP   = 0;
    localparam int USER_VALVES = 1;
    localparam int USER_BITS   = 2;

    typedef logic signed [ACC_BITS-1:0] coef_t;

    // Load enables of the three lane pipeline stages.
    typedef struct packed {
        logic ld_mul;
        logic ld_add;
        logic ld_out;
    } pipe_ctrl_t;

    // Low-pass kernel, symmetric over taps zero to eight; taps ten and up are zero.
    function automatic coef_t coef(input int t);
        coef_t c;
        case (t)
            0:       c = -32'sd87;
            1:       c = -32'sd2085;
            2:       c = 32'sd2358;
            3:       c = 32'sd18158;
            4:       c = 32'sd28406;
            5:       c = 32'sd18158;
            6:       c = 32'sd2358;
            7:       c = -32'sd2085;
            8:       c = -32'sd87;
            9:       c = 32'sd444;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

[rtl/core/qfvt_lane.sv]
// One channel: delay line, constant multiplies, pairwise adds and final sum.
module qfvt_lane #(
    parameter int TAPS        = 10,
    parameter int SAMPLE_BITS = 12,
    parameter int LANE_INDEX  = 0
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  qfvt_pkg::pipe_ctrl_t             ctrl,
    input  logic [SAMPLE_BITS-1:0]           sample,
    output logic [qfvt_pkg::OUT_BITS-1:0]    filtered
);
    import qfvt_pkg::*;

    localparam int NPAIR = (TAPS + 1) / 2;

    logic [SAMPLE_BITS-1:0] line_reg  [TAPS];
    logic [SAMPLE_BITS-1:0] line_next [TAPS];
    logic [ACC_BITS-1:0]    prod_reg  [TAPS];
    logic [ACC_BITS-1:0]    prod_next [TAPS];
    logic [ACC_BITS-1:0]    pair_reg  [NPAIR];
    logic [ACC_BITS-1:0]    pair_next [NPAIR];
    logic [ACC_BITS-1:0]    sum_next;
    logic [OUT_BITS-1:0]    filtered_reg;

    always_comb begin
        line_next[0] = sample;
        for (int t = 1; t < TAPS; t++) begin
            line_next[t] = line_reg[t-1];
        end
    end

    // Products wrap to 32 bits, as does the whole sum.
    always_comb begin
        for (int t = 0; t < TAPS; t++) begin
            prod_next[t] = ACC_BITS'(coef(t))
                         * {{(ACC_BITS-SAMPLE_BITS){1'b0}}, line_next[t]};
        end
    end

    for (genvar i = 0; i < NPAIR; i++) begin : g_pair
        if (2*i + 1 < TAPS) begin : g_two
            assign pair_next[i] = prod_reg[2*i] + prod_reg[2*i+1];
        end else begin : g_one
            assign pair_next[i] = prod_reg[2*i];
        end
    end

    always_comb begin
        sum_next = '0;
        for (int i = 0; i < NPAIR; i++) begin
            sum_next = sum_next + pair_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int t = 0; t < TAPS; t++) begin
                line_reg[t] <= (t == 0) ? SAMPLE_BITS'(LANE_INDEX + 1) : '0;
            end
        end else if (ctrl.ld_mul) begin
            line_reg <= line_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld_mul) begin
            prod_reg <= prod_next;
        end
        if (ctrl.ld_add) begin
            pair_reg <= pair_next;
        end
        if (ctrl.ld_out) begin
            filtered_reg <= sum_next[ACC_BITS-1 -: OUT_BITS];
        end
    end

    assign filtered = filtered_reg;

endmodule

[rtl/core/qfvt_ctrl.sv]
// Pipeline handshake, timeout counter, compensation edge detect and flag staging.
module qfvt_ctrl (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic                               comp_on,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [qfvt_pkg::LIMIT_BITS-1:0]    cfg_data,
    output qfvt_pkg::pipe_ctrl_t               ctrl,
    output logic                               comp_request,
    output logic                               valves_off
);
    import qfvt_pkg::*;

    typedef struct packed {
        logic valves;
        logic comp;
    } flags_t;

    logic                  v1_reg, v2_reg, v3_reg;
    logic                  rdy1, rdy2, rdy3;
    logic                  accept;
    logic [LIMIT_BITS-1:0] limit_reg;
    logic [LIMIT_BITS-1:0] tick_reg, tick_next;
    logic                  prev_comp_reg, prev_comp_next;
    flags_t                flags_next, f1_reg, f2_reg, f3_reg;

    // Bubbles collapse: a stage takes data when it is empty or drains.
    assign rdy3   = !v3_reg || m_tready;
    assign rdy2   = !v2_reg || rdy3;
    assign rdy1   = !v1_reg || rdy2;
    assign accept = s_tvalid && rdy1;

    assign s_tready    = rdy1;
    assign cfg_ready   = 1'b1;
    assign ctrl.ld_mul = accept;
    assign ctrl.ld_add = v1_reg && rdy2;
    assign ctrl.ld_out = v2_reg && rdy3;

    always_comb begin
        flags_next.valves = 1'b0;
        flags_next.comp   = comp_on;
        tick_next         = tick_reg + 1'b1;
        prev_comp_next    = prev_comp_reg;
        if (tick_reg > limit_reg) begin
            flags_next.valves = 1'b1;
            tick_next         = '0;
        end
        if (comp_on) begin
            prev_comp_next = 1'b1;
        end else if (prev_comp_reg) begin
            flags_next.valves = 1'b1;
            prev_comp_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            limit_reg     <= LIMIT_RESET;
            tick_reg      <= '0;
            prev_comp_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_tvalid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (cfg_valid) begin
                limit_reg <= cfg_data;
            end
            if (accept) begin
                tick_reg      <= tick_next;
                prev_comp_reg <= prev_comp_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld_mul) begin
            f1_reg <= flags_next;
        end
        if (ctrl.ld_add) begin
            f2_reg <= f1_reg;
        end
        if (ctrl.ld_out) begin
            f3_reg <= f2_reg;
        end
    end

    assign m_tvalid     = v3_reg;
    assign comp_request = f3_reg.comp;
    assign valves_off   = f3_reg.valves;

endmodule

[rtl/core/quad_fir_with_valve_timeout_unit.sv]
// An accepted s_ transaction passes the registered multiply, pair add and sum stages to reach m_tvalid.
// Throughput: one transaction per cycle while m_tready is high; each stage of the lane pipeline holds one item.
// The output register is a stage of its own, so input is taken while a result waits, if an earlier stage is empty.
// Reset (synchronous, aresetn low) empties the pipeline, presets each delay line
// (tap 0 of channel c holds c+1), clears the tick counter and sets the limit to 50.
module quad_fir_with_valve_timeout_unit #(
    parameter int TAPS        = 10,
    parameter int CHANNELS    = 4,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // sample_ch0, sample_ch1, ... (SAMPLE_BITS each), zero padding to bytes
    input  logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // compensation_on
    input  logic                                     s_tuser,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // filtered_ch0, filtered_ch1, ... (16 bits each)
    output logic [CHANNELS*qfvt_pkg::OUT_BITS-1:0]   m_tdata,
    // compensation_request, valves_off
    output logic [qfvt_pkg::USER_BITS-1:0]           m_tuser,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    // timeout_limit
    input  logic [qfvt_pkg::LIMIT_BITS-1:0]          cfg_data
);
    import qfvt_pkg::*;

    pipe_ctrl_t ctrl;
    logic       comp_request;
    logic       valves_off;

    qfvt_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .comp_on      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .ctrl         (ctrl),
        .comp_request (comp_request),
        .valves_off   (valves_off)
    );

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        qfvt_lane #(
            .TAPS        (TAPS),
            .SAMPLE_BITS (SAMPLE_BITS),
            .LANE_INDEX  (c)
        ) u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .sample   (s_tdata[c*SAMPLE_BITS +: SAMPLE_BITS]),
            .filtered (m_tdata[c*OUT_BITS +: OUT_BITS])
        );
    end

    assign m_tuser[USER_COMP]   = comp_request;
    assign m_tuser[USER_VALVES] = valves_off;

endmodule

[rtl/core/qfvt_checker.sv]
// Port-level checks of the quad FIR block and their bind to the top level.
`include "quad_fir_with_valve_timeout_unit_defines.svh"

module qfvt_checker #(
    parameter int DATA_BITS = 64
) (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [DATA_BITS-1:0]                 m_tdata,
    input logic [qfvt_pkg::USER_BITS-1:0]       m_tuser
);
    // A stalled result holds.
    `QFVT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Leaving reset, the pipeline is empty and input is taken.
    `QFVT_ASSERT_IMPLIES(a_reset_empty, aclk, aresetn, $past(!aresetn), s_tready && !m_tvalid)

    // If the output was idle and no input was taken, nothing is left to emerge.
    `QFVT_ASSERT_IMPLIES(a_drained, aclk, aresetn, !$past(m_tvalid, 1) && !$past(m_tvalid, 2) && !$past(m_tvalid, 3) && !$past(s_tvalid && s_tready, 1) && !$past(s_tvalid && s_tready, 2) && !$past(s_tvalid && s_tready, 3), !m_tvalid)

endmodule

bind quad_fir_with_valve_timeout_unit qfvt_checker #(
    .DATA_BITS (CHANNELS*qfvt_pkg::OUT_BITS)
) u_qfvt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
